// File: hw/rtl/sce_pkg.sv
// Shared types, constants and helper functions of the spinal code encoder.
package sce_pkg;

  // Field widths
  localparam int MSG_W  = 16;
  localparam int SYM_W  = 12;
  localparam int PNUM_W = 6;

  // Configuration port
  localparam int CFG_DATA_W = 7;
  localparam logic [0:0] CFG_SYMBOL_SIZE = 1'b0;
  localparam logic [0:0] CFG_NUM_PASSES  = 1'b1;
  localparam logic [4:0] SYMBOL_SIZE_RST = 5'd4;
  localparam logic [6:0] NUM_PASSES_RST  = 7'd4;

  // Parameter defaults
  localparam int MAX_SYMBOL_BITS_DEF = 16;
  localparam int MAX_PASSES_DEF      = 64;

  // Spine hash
  localparam logic [31:0] FNV_OFFSET = 32'h811c9dc5;
  localparam logic [31:0] FNV_PRIME  = 32'h01000193;

  // Pass mixing
  localparam logic [31:0] MIX_MUL  = 32'd2654435761;
  localparam logic [15:0] PASS_MUL = 16'd40503;
  localparam logic [31:0] MIX_C    = 32'h045d9f3b;
  localparam logic [31:0] MIX_ADD  = 32'h1b56c4e9;

  // Log / radius / angle
  localparam logic [31:0] LN2_Q32     = 32'd2977044472;
  localparam logic [29:0] LOG2_1E10   = 30'd557327052;
  localparam logic [31:0] TWO_PI_LO   = 32'd1216271633;
  localparam logic [2:0]  TWO_PI_HI   = 3'd6;
  localparam logic [29:0] CORDIC_GAIN = 30'd652032874;

  // Iteration counts
  localparam logic [4:0] LOG_STEPS    = 5'd24;
  localparam logic [4:0] SQRT_STEPS   = 5'd28;
  localparam logic [4:0] CORDIC_STEPS = 5'd30;
  localparam int         SQRT_TOP     = 54;

  // Sequencer states
  typedef enum logic [1:0] {
    T_IDLE,
    T_HASH,
    T_RUN,
    T_WAIT
  } top_state_e;

  typedef enum logic [3:0] {
    G_IDLE,
    G_MIX0,
    G_MIX1,
    G_MIX2,
    G_LOG,
    G_LN,
    G_SQRT,
    G_ZMUL,
    G_CORD,
    G_FIN,
    G_DONE
  } gauss_state_e;

  // Control from the sequencer to the Gaussian unit
  typedef struct packed {
    logic start;
    logic ack;
  } gctl_t;

  // Arctangent of 2^-i, Q30
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] r;
    unique case (i)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043837;
      5'd3:  r = 30'd133525159;
      5'd4:  r = 30'd67021687;
      5'd5:  r = 30'd33543516;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048576;
      5'd11: r = 30'd524288;
      5'd12: r = 30'd262144;
      5'd13: r = 30'd131072;
      5'd14: r = 30'd65536;
      5'd15: r = 30'd32768;
      5'd16: r = 30'd16384;
      5'd17: r = 30'd8192;
      5'd18: r = 30'd4096;
      5'd19: r = 30'd2048;
      5'd20: r = 30'd1024;
      5'd21: r = 30'd512;
      5'd22: r = 30'd256;
      5'd23: r = 30'd128;
      5'd24: r = 30'd64;
      5'd25: r = 30'd32;
      5'd26: r = 30'd16;
      5'd27: r = 30'd8;
      5'd28: r = 30'd4;
      5'd29: r = 30'd2;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  // Index of the highest set bit of a 24-bit uniform
  function automatic logic [4:0] top_bit(input logic [23:0] k);
    logic [4:0] e;
    e = 5'd0;
    for (int i = 0; i < 24; i++) begin
      if (k[i]) e = 5'(i);
    end
    return e;
  endfunction

endpackage

// File: hw/rtl/sce_in_if.sv
// Input channel: one message bit group per word.
interface sce_in_if;
  logic                         valid;
  logic                         ready;
  logic [sce_pkg::MSG_W-1:0]    message_bits;
  logic                         start_of_message;

  modport source (output valid, message_bits, start_of_message, input ready);
  modport sink   (input valid, message_bits, start_of_message, output ready);
endinterface

// File: hw/rtl/sce_out_if.sv
// Output channel: one Gaussian symbol per word.
interface sce_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [sce_pkg::SYM_W-1:0]  symbol;
  logic [sce_pkg::PNUM_W-1:0]        pass_number;
  logic                              last_of_group;

  modport source (output valid, symbol, pass_number, last_of_group, input ready);
  modport sink   (input valid, symbol, pass_number, last_of_group, output ready);
endinterface

// File: hw/rtl/sce_gauss.sv
// Gaussian symbol unit: mixing, log, sqrt and CORDIC in one sequential datapath, with one shared multiplier.
module sce_gauss #(
  parameter int PASS_W = 6
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sce_pkg::gctl_t            ctl_i,
  input  logic [31:0]               spine_i,
  input  logic [PASS_W-1:0]         pass_i,
  output logic                      done_o,
  output logic [sce_pkg::SYM_W-1:0] sym_o
);

  sce_pkg::gauss_state_e state_q, state_d;
  logic [4:0]  cnt_q, cnt_d;
  logic [39:0] s_q, s_d;
  logic [23:0] k1_q, k1_d, k2_q, k2_d;
  logic [4:0]  e_q, e_d;
  logic [30:0] m_q, m_d;
  logic [23:0] frac_q, frac_d;
  logic [55:0] v_q, v_d, res_q, res_d, bit_q, bit_d;
  logic signed [32:0] x_q, x_d, y_q, y_d, z_q, z_d;
  logic [sce_pkg::SYM_W-1:0] sym_q, sym_d;

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic [4:0]  tb;
  logic [31:0] msq;
  logic [29:0] t_val;
  logic [55:0] trial;
  logic [63:0] zsum;
  logic signed [32:0] xs, ys, at;
  logic signed [33:0] cval;
  logic        cneg;
  logic [33:0] cmag;
  logic [59:0] rnd;
  logic [13:0] mag;

  assign mul_p = 64'(mul_a) * 64'(mul_b);

  // -log2(u1) in Q24
  assign t_val = (k1_q == 24'd0) ? sce_pkg::LOG2_1E10
               : (30'(5'd24 - e_q) << 24) - 30'(frac_q);

  // cosine by quadrant
  always_comb begin
    unique case (k2_q[23:22])
      2'd0: cval = 34'(x_q);
      2'd1: cval = -34'(y_q);
      2'd2: cval = -34'(x_q);
      2'd3: cval = 34'(y_q);
    endcase
  end
  assign cneg = cval[33];
  assign cmag = cneg ? 34'(-cval) : 34'(cval);

  assign tb    = sce_pkg::top_bit(k1_q);
  assign msq   = mul_p[61:30];
  assign trial = res_q + bit_q;
  assign zsum  = mul_p + ((64'(k2_q[21:0]) * 64'(sce_pkg::TWO_PI_HI)) << 32);
  assign xs    = x_q >>> cnt_q;
  assign ys    = y_q >>> cnt_q;
  assign at    = $signed({3'b000, sce_pkg::atan_q30(cnt_q)});
  assign rnd   = mul_p[59:0] + (60'd1 << 45);
  assign mag   = rnd[59:46];

  // operand select
  always_comb begin
    unique case (state_q)
      sce_pkg::G_MIX0: begin
        mul_a = spine_i;
        mul_b = sce_pkg::MIX_MUL;
      end
      sce_pkg::G_MIX1: begin
        mul_a = 32'(s_q[23:0] ^ s_q[39:16]);
        mul_b = sce_pkg::MIX_C;
      end
      sce_pkg::G_MIX2: begin
        mul_a = 32'(k1_q);
        mul_b = sce_pkg::MIX_C;
      end
      sce_pkg::G_LOG: begin
        mul_a = 32'(m_q);
        mul_b = 32'(m_q);
      end
      sce_pkg::G_LN: begin
        mul_a = 32'(t_val);
        mul_b = sce_pkg::LN2_Q32;
      end
      sce_pkg::G_ZMUL: begin
        mul_a = 32'(k2_q[21:0]);
        mul_b = sce_pkg::TWO_PI_LO;
      end
      sce_pkg::G_FIN: begin
        mul_a = res_q[31:0];
        mul_b = cmag[31:0];
      end
      default: begin
        mul_a = 32'd0;
        mul_b = 32'd0;
      end
    endcase
  end

  // sequencer and datapath next state
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    s_d     = s_q;
    k1_d    = k1_q;
    k2_d    = k2_q;
    e_d     = e_q;
    m_d     = m_q;
    frac_d  = frac_q;
    v_d     = v_q;
    res_d   = res_q;
    bit_d   = bit_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    sym_d   = sym_q;
    done_o  = 1'b0;
    unique case (state_q)
      sce_pkg::G_IDLE: begin
        if (ctl_i.start) state_d = sce_pkg::G_MIX0;
      end
      sce_pkg::G_MIX0: begin
        s_d     = mul_p[39:0] + 40'(pass_i) * 40'(sce_pkg::PASS_MUL);
        state_d = sce_pkg::G_MIX1;
      end
      sce_pkg::G_MIX1: begin
        k1_d    = mul_p[23:0];
        state_d = sce_pkg::G_MIX2;
      end
      sce_pkg::G_MIX2: begin
        k2_d    = mul_p[23:0] + sce_pkg::MIX_ADD[23:0];
        e_d     = tb;
        m_d     = 31'(k1_q) << (5'd30 - tb);
        frac_d  = 24'd0;
        cnt_d   = 5'd0;
        state_d = (k1_q == 24'd0) ? sce_pkg::G_LN : sce_pkg::G_LOG;
      end
      sce_pkg::G_LOG: begin
        // square, renormalize, shift one fraction bit in
        if (msq[31]) begin
          m_d    = msq[31:1];
          frac_d = {frac_q[22:0], 1'b1};
        end else begin
          m_d    = msq[30:0];
          frac_d = {frac_q[22:0], 1'b0};
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == sce_pkg::LOG_STEPS - 5'd1) state_d = sce_pkg::G_LN;
      end
      sce_pkg::G_LN: begin
        v_d     = 56'(mul_p[61:31]) << 24;
        res_d   = 56'd0;
        bit_d   = 56'd1 << sce_pkg::SQRT_TOP;
        cnt_d   = 5'd0;
        state_d = sce_pkg::G_SQRT;
      end
      sce_pkg::G_SQRT: begin
        if (v_q >= trial) begin
          v_d   = v_q - trial;
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == sce_pkg::SQRT_STEPS - 5'd1) state_d = sce_pkg::G_ZMUL;
      end
      sce_pkg::G_ZMUL: begin
        z_d     = $signed({2'b00, zsum[56:26]});
        x_d     = $signed({3'b000, sce_pkg::CORDIC_GAIN});
        y_d     = 33'sd0;
        cnt_d   = 5'd0;
        state_d = sce_pkg::G_CORD;
      end
      sce_pkg::G_CORD: begin
        if (!z_q[32]) begin
          x_d = x_q - ys;
          y_d = y_q + xs;
          z_d = z_q - at;
        end else begin
          x_d = x_q + ys;
          y_d = y_q - xs;
          z_d = z_q + at;
        end
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == sce_pkg::CORDIC_STEPS - 5'd1) state_d = sce_pkg::G_FIN;
      end
      sce_pkg::G_FIN: begin
        // round half away from zero, then apply sign
        sym_d   = cneg ? 12'(~mag + 14'd1) : mag[11:0];
        state_d = sce_pkg::G_DONE;
      end
      sce_pkg::G_DONE: begin
        done_o = 1'b1;
        if (ctl_i.ack) state_d = sce_pkg::G_IDLE;
      end
      default: state_d = sce_pkg::G_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sce_pkg::G_IDLE;
      cnt_q   <= 5'd0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q    <= s_d;
    k1_q   <= k1_d;
    k2_q   <= k2_d;
    e_q    <= e_d;
    m_q    <= m_d;
    frac_q <= frac_d;
    v_q    <= v_d;
    res_q  <= res_d;
    bit_q  <= bit_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    sym_q  <= sym_d;
  end

  assign sym_o = sym_q;

  // start only lands on an idle unit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.start |-> state_q == sce_pkg::G_IDLE)
    else $error("gauss start while busy");

  // log mantissa stays normalized in [1,2)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == sce_pkg::G_LOG |-> m_q[30])
    else $error("log mantissa not normalized");

  // finished symbol within the constellation range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> ($signed(sym_q) <= 12'sd1739 && $signed(sym_q) >= -12'sd1739))
    else $error("symbol out of range");

endmodule

// File: hw/rtl/spinal_code_encoder_top.sv
// Spinal code encoder top: config, spine hash, pass sequencer, output register.
//
//  channel  | dir | handshake      | word
//  ---------+-----+----------------+------------------------------------------
//  grp_i    | in  | valid / ready  | message_bits[15:0], start_of_message
//  sym_o    | out | valid / ready  | symbol[11:0] signed, pass_number[5:0],
//           |     |                | last_of_group
//  cfg      | in  | cfg_we_i       | cfg_idx_i, cfg_data_i[6:0]
//
// A group is hashed one bit per cycle, then each pass runs 24 log squarings
// (skipped when k1 is zero), 28 sqrt steps and 30 CORDIC rotations in one
// datapath; mixing, log, ln, angle and scaling share one 32x32 multiplier.
// grp_i.ready is high only while the sequencer is idle.
// A stalled sym_o holds the next symbol in the Gaussian unit; the last
// symbol of a group waits in the output register while a new group enters.
// Reset (async, active low) clears the spine and loads the config defaults.
module spinal_code_encoder_top #(
  parameter int MAX_SYMBOL_BITS = sce_pkg::MAX_SYMBOL_BITS_DEF,
  parameter int MAX_PASSES      = sce_pkg::MAX_PASSES_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [0:0]                     cfg_idx_i,
  input  logic [sce_pkg::CFG_DATA_W-1:0] cfg_data_i,
  sce_in_if.sink                         grp_i,
  sce_out_if.source                      sym_o
);

  localparam int SCW = $clog2(MAX_SYMBOL_BITS + 1);
  localparam int NPW = $clog2(MAX_PASSES + 1);
  localparam int PW  = (MAX_PASSES > 1) ? $clog2(MAX_PASSES) : 1;

  sce_pkg::top_state_e state_q, state_d;
  logic [4:0]                 symsize_q;
  logic [6:0]                 numpass_q;
  logic [31:0]                spine_q, spine_d, h_q, h_d;
  logic [MAX_SYMBOL_BITS-1:0] msg_q, msg_d;
  logic [SCW-1:0]             bcnt_q, bcnt_d, nbits_q, nbits_d, nbits_c;
  logic [NPW-1:0]             npass_q, npass_d, npass_c;
  logic [PW-1:0]              pass_q, pass_d;
  logic                       ov_q;
  logic [sce_pkg::SYM_W-1:0]  osym_q;
  logic [sce_pkg::PNUM_W-1:0] opass_q;
  logic                       olast_q;

  sce_pkg::gctl_t             gctl;
  logic                       gdone;
  logic [sce_pkg::SYM_W-1:0]  gsym;
  logic                       slot_free, last_pass;
  logic [31:0]                hb;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      symsize_q <= sce_pkg::SYMBOL_SIZE_RST;
      numpass_q <= sce_pkg::NUM_PASSES_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sce_pkg::CFG_SYMBOL_SIZE: symsize_q <= cfg_data_i[4:0];
        sce_pkg::CFG_NUM_PASSES:  numpass_q <= cfg_data_i;
      endcase
    end
  end

  // clamp config into the supported range
  always_comb begin
    priority if (symsize_q == 5'd0)             nbits_c = SCW'(1);
    else if (32'(symsize_q) > MAX_SYMBOL_BITS)  nbits_c = SCW'(MAX_SYMBOL_BITS);
    else                                        nbits_c = SCW'(symsize_q);
    priority if (numpass_q == 7'd0)             npass_c = NPW'(1);
    else if (32'(numpass_q) > MAX_PASSES)       npass_c = NPW'(MAX_PASSES);
    else                                        npass_c = NPW'(numpass_q);
  end

  assign slot_free = !ov_q || sym_o.ready;
  assign last_pass = (NPW'(pass_q) == npass_q - NPW'(1));
  assign hb        = h_q ^ {31'd0, msg_q[0]};

  // sequencer
  always_comb begin
    state_d     = state_q;
    spine_d     = spine_q;
    h_d         = h_q;
    msg_d       = msg_q;
    bcnt_d      = bcnt_q;
    nbits_d     = nbits_q;
    npass_d     = npass_q;
    pass_d      = pass_q;
    gctl.start  = 1'b0;
    gctl.ack    = 1'b0;
    grp_i.ready = 1'b0;
    unique case (state_q)
      sce_pkg::T_IDLE: begin
        grp_i.ready = 1'b1;
        if (grp_i.valid) begin
          h_d     = (grp_i.start_of_message ? 32'd0 : spine_q) ^ sce_pkg::FNV_OFFSET;
          msg_d   = grp_i.message_bits[MAX_SYMBOL_BITS-1:0];
          bcnt_d  = '0;
          nbits_d = nbits_c;
          npass_d = npass_c;
          state_d = sce_pkg::T_HASH;
        end
      end
      sce_pkg::T_HASH: begin
        // one message bit per cycle
        h_d    = hb * sce_pkg::FNV_PRIME;
        msg_d  = msg_q >> 1;
        bcnt_d = bcnt_q + SCW'(1);
        if (bcnt_q == nbits_q - SCW'(1)) begin
          spine_d = h_d;
          pass_d  = '0;
          state_d = sce_pkg::T_RUN;
        end
      end
      sce_pkg::T_RUN: begin
        gctl.start = 1'b1;
        state_d    = sce_pkg::T_WAIT;
      end
      sce_pkg::T_WAIT: begin
        if (gdone && slot_free) begin
          gctl.ack = 1'b1;
          if (last_pass) begin
            state_d = sce_pkg::T_IDLE;
          end else begin
            pass_d  = pass_q + PW'(1);
            state_d = sce_pkg::T_RUN;
          end
        end
      end
      default: state_d = sce_pkg::T_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sce_pkg::T_IDLE;
      spine_q <= 32'd0;
      bcnt_q  <= '0;
      nbits_q <= '0;
      npass_q <= '0;
      pass_q  <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      spine_q <= spine_d;
      bcnt_q  <= bcnt_d;
      nbits_q <= nbits_d;
      npass_q <= npass_d;
      pass_q  <= pass_d;
      if (gctl.ack)         ov_q <= 1'b1;
      else if (sym_o.ready) ov_q <= 1'b0;
    end
  end

  // hash and output payload
  always_ff @(posedge clk_i) begin
    h_q   <= h_d;
    msg_q <= msg_d;
    if (gctl.ack) begin
      osym_q  <= gsym;
      opass_q <= sce_pkg::PNUM_W'(pass_q);
      olast_q <= last_pass;
    end
  end

  sce_gauss #(
    .PASS_W (PW)
  ) u_gauss (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (gctl),
    .spine_i (spine_q),
    .pass_i  (pass_q),
    .done_o  (gdone),
    .sym_o   (gsym)
  );

  assign sym_o.valid         = ov_q;
  assign sym_o.symbol        = $signed(osym_q);
  assign sym_o.pass_number   = opass_q;
  assign sym_o.last_of_group = olast_q;

  // busy right after a group is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    grp_i.valid && grp_i.ready |=> !grp_i.ready)
    else $error("group accepted while busy");

  // pass index stays below the pass count while symbols are produced
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sce_pkg::T_RUN || state_q == sce_pkg::T_WAIT)
      |-> NPW'(pass_q) < npass_q)
    else $error("pass index out of range");

  // a word handed to the output register is valid next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    gctl.ack |=> ov_q)
    else $error("symbol word lost");

endmodule
